@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/bxds_pkg.sv @@
`timescale 1ns / 1ps

package bxds_pkg;

	// Sizing of the line store and the block factor
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_FACTOR = 8;
	localparam int ROW_LIMIT  = 1024;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(ROW_LIMIT);
	localparam int PIX_W  = 8;
	localparam int CSUM_W = 11;
	localparam int SUM_W  = 14;
	localparam int CFG_W  = 11;
	localparam int FAC_W  = 4;
	localparam int PH_W   = 3;
	localparam int IDX_W  = 2;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_DOWN_FACTOR  = 2'd2;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;
	localparam logic [FAC_W-1:0] DOWN_FACTOR_RST  = 4'd2;

	// Reciprocal of D, scaled by 2^14, rounded up
	localparam int RL_W     = 15;
	localparam int RL_SHIFT = 14;
	// Reciprocal of D*D, scaled by 2^20, rounded up
	localparam int RS_W     = 21;
	localparam int RS_SHIFT = 20;
	localparam int QUOT_W   = SUM_W + 1;

	typedef struct packed {
		logic capture;
		logic calc_quot;
		logic calc_limit;
		logic update;
		logic load_out;
	} bxds_cmd_t;

	typedef struct packed {
		logic emit;
		logic out_busy;
	} bxds_stat_t;

	function automatic logic [RL_W-1:0] recip_lin(input logic [FAC_W-1:0] d);
		logic [RL_W-1:0] r;
		unique case (d)
			4'd2:    r = 15'd8192;
			4'd3:    r = 15'd5462;
			4'd4:    r = 15'd4096;
			4'd5:    r = 15'd3277;
			4'd6:    r = 15'd2731;
			4'd7:    r = 15'd2341;
			4'd8:    r = 15'd2048;
			default: r = 15'd16384;
		endcase
		return r;
	endfunction

	function automatic logic [RS_W-1:0] recip_sq(input logic [FAC_W-1:0] d);
		logic [RS_W-1:0] r;
		unique case (d)
			4'd2:    r = 21'd262144;
			4'd3:    r = 21'd116509;
			4'd4:    r = 21'd65536;
			4'd5:    r = 21'd41944;
			4'd6:    r = 21'd29128;
			4'd7:    r = 21'd21400;
			4'd8:    r = 21'd16384;
			default: r = 21'd1048576;
		endcase
		return r;
	endfunction

endpackage

@@ design/bxds_ram.sv @@
`timescale 1ns / 1ps

module bxds_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/bxds_ctrl.sv @@
`timescale 1ns / 1ps

module bxds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bxds_pkg::bxds_stat_t stat,
	output bxds_pkg::bxds_cmd_t  cmd
);

	import bxds_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_QUOT   = 3'd1;
	localparam logic [2:0] S_LIMIT  = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	assign in_ready = (state_q == S_IDLE);

	// Sequence one pixel transaction through the datapath
	always_comb begin
		state_n        = state_q;
		cmd            = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = S_QUOT;
				end
			end
			S_QUOT: begin
				cmd.calc_quot = 1'b1;
				state_n       = S_LIMIT;
			end
			S_LIMIT: begin
				cmd.calc_limit = 1'b1;
				state_n        = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_n    = S_OUT;
			end
			S_OUT: begin
				// hold until the output register can take the result
				if (!stat.emit) begin
					state_n = S_IDLE;
				end else if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

@@ design/bxds_dp.sv @@
`timescale 1ns / 1ps

module bxds_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [bxds_pkg::IDX_W-1:0]          cfg_index,
	input  logic [bxds_pkg::CFG_W-1:0]          cfg_data,
	input  logic [bxds_pkg::PIX_W-1:0]          pixel_in,
	input  logic                                start_of_frame,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bxds_pkg::PIX_W-1:0]          pixel_out,
	output logic                                last_of_frame,
	input  bxds_pkg::bxds_cmd_t                 cmd,
	output bxds_pkg::bxds_stat_t                stat
);

	import bxds_pkg::*;

	// Configuration registers
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [FAC_W-1:0] down_factor_q;

	// Position state
	logic [COL_W-1:0]  col_q, col_n;
	logic [ROW_W-1:0]  row_q, row_n;
	logic [PH_W-1:0]   cph_q, cph_n;
	logic [PH_W-1:0]   rph_q, rph_n;
	logic [COL_W-1:0]  bcol_q, bcol_n;
	logic [CSUM_W-1:0] csum_q, csum_n;
	logic [PIX_W-1:0]  pix_q;

	// Stage registers
	logic [CFG_W-1:0] bw_s1, bh_s1;
	logic [ROW_W-1:0] rblk_s1;
	logic [CFG_W-1:0] bwd_s2, bhd_s2;
	logic [SUM_W-1:0] rs_s3;
	logic             emit_s3, last_s3;

	// Output register
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic             last_q;

	logic [CFG_W-1:0] w_eff, h_eff;
	logic [FAC_W-1:0] d_eff, d_m1;
	logic [CFG_W+RL_W-1:0] bw_prod, bh_prod;
	logic [ROW_W+RL_W-1:0] row_prod;
	logic [CFG_W+FAC_W-1:0] bwd_prod, bhd_prod;
	logic              in_blk, blk_end, row_end;
	logic [CSUM_W-1:0] csum_new;
	logic [SUM_W-1:0]  rs, ram_rdata;
	logic [CFG_W-1:0]  bcol_p1, rblk_p1, col_p1, row_p1;
	logic              last_c, ram_we;
	logic [SUM_W+RS_W-1:0] sq_prod;
	logic [QUOT_W-1:0] quot;
	logic [PIX_W-1:0]  avg;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			down_factor_q  <= DOWN_FACTOR_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_DOWN_FACTOR:  down_factor_q  <= cfg_data[FAC_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers into their working ranges
	always_comb begin
		priority if (frame_width_q == '0) w_eff = CFG_W'(1);
		else if (frame_width_q > CFG_W'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
		else w_eff = frame_width_q;

		priority if (frame_height_q == '0) h_eff = CFG_W'(1);
		else if (frame_height_q > CFG_W'(ROW_LIMIT)) h_eff = CFG_W'(ROW_LIMIT);
		else h_eff = frame_height_q;

		priority if (down_factor_q == '0) d_eff = FAC_W'(1);
		else if (down_factor_q > FAC_W'(MAX_FACTOR)) d_eff = FAC_W'(MAX_FACTOR);
		else d_eff = down_factor_q;
	end

	assign d_m1 = d_eff - FAC_W'(1);

	// Stage 1: whole blocks per row and column, block row of this pixel
	assign bw_prod  = w_eff * recip_lin(d_eff);
	assign bh_prod  = h_eff * recip_lin(d_eff);
	assign row_prod = row_q * recip_lin(d_eff);

	// Stage 2: extent covered by whole blocks
	assign bwd_prod = bw_s1 * d_eff;
	assign bhd_prod = bh_s1 * d_eff;

	always_ff @(posedge clk) begin
		if (cmd.calc_quot) begin
			bw_s1   <= bw_prod[RL_SHIFT +: CFG_W];
			bh_s1   <= bh_prod[RL_SHIFT +: CFG_W];
			rblk_s1 <= row_prod[RL_SHIFT +: ROW_W];
		end
		if (cmd.calc_limit) begin
			bwd_s2 <= bwd_prod[CFG_W-1:0];
			bhd_s2 <= bhd_prod[CFG_W-1:0];
		end
	end

	// Stage 3: accumulate and decide on a result
	assign in_blk   = ({1'b0, col_q} < bwd_s2) && ({1'b0, row_q} < bhd_s2);
	assign csum_new = (cph_q == '0) ? CSUM_W'(pix_q) : csum_q + CSUM_W'(pix_q);
	assign blk_end  = {1'b0, cph_q} >= d_m1;
	assign row_end  = {1'b0, rph_q} >= d_m1;
	assign rs       = (rph_q != '0) ? SUM_W'(csum_new) + ram_rdata : SUM_W'(csum_new);
	assign bcol_p1  = {1'b0, bcol_q} + CFG_W'(1);
	assign rblk_p1  = {1'b0, rblk_s1} + CFG_W'(1);
	assign last_c   = (bcol_p1 >= bw_s1) && (rblk_p1 >= bh_s1);
	assign ram_we   = cmd.update && in_blk && blk_end && !row_end;
	assign col_p1   = {1'b0, col_q} + CFG_W'(1);
	assign row_p1   = {1'b0, row_q} + CFG_W'(1);

	// Advance the position counters past this pixel
	always_comb begin
		col_n  = col_q;
		row_n  = row_q;
		cph_n  = cph_q;
		rph_n  = rph_q;
		bcol_n = bcol_q;
		csum_n = csum_q;
		if (in_blk) begin
			if (blk_end) begin
				csum_n = '0;
				cph_n  = '0;
				bcol_n = bcol_p1[COL_W-1:0];
			end else begin
				cph_n  = cph_q + PH_W'(1);
				csum_n = csum_new;
			end
		end
		if (col_p1 >= w_eff) begin
			col_n  = '0;
			cph_n  = '0;
			bcol_n = '0;
			csum_n = '0;
			rph_n  = row_end ? '0 : rph_q + PH_W'(1);
			if (row_p1 >= h_eff) begin
				row_n = '0;
				rph_n = '0;
			end else begin
				row_n = row_p1[ROW_W-1:0];
			end
		end else begin
			col_n = col_p1[COL_W-1:0];
		end
	end

	// Capture a pixel, clear on start of frame, update after the pixel is summed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			bcol_q <= '0;
			csum_q <= '0;
		end else if (cmd.capture && start_of_frame) begin
			col_q  <= '0;
			row_q  <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			bcol_q <= '0;
			csum_q <= '0;
		end else if (cmd.update) begin
			col_q  <= col_n;
			row_q  <= row_n;
			cph_q  <= cph_n;
			rph_q  <= rph_n;
			bcol_q <= bcol_n;
			csum_q <= csum_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= pixel_in;
		end
		if (cmd.update) begin
			rs_s3   <= rs;
			last_s3 <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s3 <= 1'b0;
		end else if (cmd.update) begin
			emit_s3 <= in_blk && blk_end && row_end;
		end
	end

	// Line store of block sums for the rows already seen in this block row
	bxds_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bcol_q),
		.wdata (rs),
		.re    (cmd.calc_limit),
		.raddr (bcol_q),
		.rdata (ram_rdata)
	);

	// Stage 4: divide by D squared and saturate
	assign sq_prod = rs_s3 * recip_sq(d_eff);
	assign quot    = sq_prod[RS_SHIFT +: QUOT_W];
	assign avg     = (quot > QUOT_W'(255)) ? '1 : quot[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pixel_out_q <= avg;
			last_q      <= last_s3;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_out     = pixel_out_q;
	assign last_of_frame = last_q;

	assign stat.emit     = emit_s3;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

@@ design/box_average_image_downscaler_core.sv @@
`timescale 1ns / 1ps
// Box-average downscaler for 8-bit grayscale pixels in raster order.
// Input channel (in_valid/in_ready): pixel_in and start_of_frame; a set
// start_of_frame restarts the position counters at row 0, column 0.
// Output channel (out_valid/out_ready): pixel_out is the truncated mean of
// one D-by-D block, last_of_frame marks the bottom-right block of a frame.
// A result leaves only on the pixel that closes its block; partial blocks at
// the right and bottom edges give nothing.
// Each pixel passes in turn through capture, reciprocal divide of the frame
// size, block extent and line-store read, accumulate and line-store write,
// then divide by D squared into the output register. The controller walks
// one pixel at a time through these steps and takes no new pixel until the
// last one is through them.
// When the receiver stalls, the output register holds its result and the
// next pixel is still taken; that pixel waits in its last step only if it
// too has a result to deliver.
// Configuration: cfg_write with cfg_index 0 (frame_width), 1 (frame_height)
// or 2 (down_factor), applied at once; write only between transactions.
// Reset sets 640 x 480, factor 2, clears counters and the output valid flag.
// The line store is not cleared; each entry is written before its read data is used.
module box_average_image_downscaler_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [bxds_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bxds_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bxds_pkg::PIX_W-1:0]   pixel_in,
	input  logic                         start_of_frame,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bxds_pkg::PIX_W-1:0]   pixel_out,
	output logic                         last_of_frame
);

	import bxds_pkg::*;

	bxds_cmd_t  cmd;
	bxds_stat_t stat;

	bxds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bxds_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel_in       (pixel_in),
		.start_of_frame (start_of_frame),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_out      (pixel_out),
		.last_of_frame  (last_of_frame),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

@@ design/bxds_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bxds_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [bxds_pkg::PIX_W-1:0] pixel_out,
	input logic                       last_of_frame
);

	logic in_txn;

	assign in_txn = in_valid && in_ready;

	// Stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(pixel_out) && $stable(last_of_frame))

	// After a pixel transaction, in_ready stays low while the transaction runs
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_txn,
		!in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)

	// A new result never blocks the input side
	`ASSERT_NOW(a_ready_on_result, clk, arst_n, $rose(out_valid), in_ready)

endmodule

bind box_average_image_downscaler_core bxds_checker u_bxds_checker (.*);
